// ===== rtl/core/i2a_pkg.sv =====
package i2a_pkg;

  localparam int VALUE_WIDTH_DEF = 64;
  localparam int STACK_DEPTH     = 64;
  localparam int DIGIT_W         = 4;
  localparam int RADIX_W         = 5;
  localparam int COUNT_W         = 7;

  localparam logic [1:0] OP_SIGNED  = 2'd0;
  localparam logic [1:0] OP_RADIX   = 2'd1;
  localparam logic [1:0] OP_POINTER = 2'd2;

  localparam logic [1:0] REG_RADIX = 2'd0;
  localparam logic [1:0] REG_UPPER = 2'd1;

  localparam logic [RADIX_W-1:0] RADIX_MIN = 5'd2;
  localparam logic [RADIX_W-1:0] RADIX_DEC = 5'd10;
  localparam logic [RADIX_W-1:0] RADIX_HEX = 5'd16;

  localparam logic [7:0] CH_ZERO  = "0";
  localparam logic [7:0] CH_LOWER = "a";
  localparam logic [7:0] CH_UPPER = "A";

  typedef struct packed {
    logic load;
    logic restart;
  } div_ctrl_t;

  typedef struct packed {
    logic done;
    logic running;
  } div_stat_t;

endpackage

// ===== rtl/core/i2a_divider.sv =====
module i2a_divider import i2a_pkg::*; #(
  parameter int DIV_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  div_ctrl_t            ctrl,
  input  logic [DIV_WIDTH-1:0] load_value,
  input  logic [RADIX_W-1:0]   divisor,
  output div_stat_t            stat,
  output logic [DIV_WIDTH-1:0] quotient,
  output logic [DIGIT_W-1:0]   remainder
);

  localparam int NIB = DIV_WIDTH / DIGIT_W;
  localparam int CW  = (NIB > 1) ? $clog2(NIB) : 1;

  logic [DIV_WIDTH-1:0] dreg;
  logic [DIGIT_W-1:0]   rem;
  logic [CW-1:0]        cnt;
  logic                 running;
  logic                 done;
  logic [DIGIT_W-1:0]   qnib;
  logic [DIGIT_W-1:0]   rem_next;

  // one radix step per dividend bit, four bits a cycle from the top
  always_comb begin
    logic [DIGIT_W:0] part;
    logic [DIGIT_W-1:0] r;
    r = rem;
    part = '0;
    qnib = '0;
    for (int i = DIGIT_W - 1; i >= 0; i--) begin
      part = {r, dreg[DIV_WIDTH-DIGIT_W+i]};
      if (part >= divisor) begin
        part = part - divisor;
        qnib[i] = 1'b1;
      end
      r = part[DIGIT_W-1:0];
    end
    rem_next = r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (ctrl.load) begin
        dreg    <= load_value;
        rem     <= '0;
        cnt     <= '0;
        running <= 1'b1;
      end else if (ctrl.restart) begin
        rem     <= '0;
        cnt     <= '0;
        running <= 1'b1;
      end else if (running) begin
        dreg <= {dreg[DIV_WIDTH-DIGIT_W-1:0], qnib};
        rem  <= rem_next;
        cnt  <= cnt + 1'b1;
        if (cnt == CW'(NIB - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  assign stat.done    = done;
  assign stat.running = running;
  assign quotient     = dreg;
  assign remainder    = rem;

endmodule

// ===== rtl/core/i2a_stack.sv =====
module i2a_stack import i2a_pkg::*; #(
  parameter int DEPTH = STACK_DEPTH
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DIGIT_W-1:0]       wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DIGIT_W-1:0]       rdata
);

  logic [DIGIT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/core/integer_to_ascii_radix.sv =====
// channel  | signals                                   | transfer
// ---------+-------------------------------------------+------------------------------
// command  | start, busy, operation, value             | edge with start && !busy
// result   | strobe, character, last, char_count       | every edge with strobe high
// config   | cfg_we, cfg_addr, cfg_wdata               | every edge with cfg_we high
//
// digits come from a serial divider that retires four dividend bits a cycle,
// one division per digit; a "-" or "0x" prefix goes out while the first
// division runs; digits are popped from the stack one per cycle; rst is
// synchronous and clears control state only; the receiver cannot stall,
// results just go out
module integer_to_ascii_radix import i2a_pkg::*; #(
  parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         operation,
  input  logic [63:0]        value,
  output logic               strobe,
  output logic [7:0]         character,
  output logic               last,
  output logic [COUNT_W-1:0] char_count,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_addr,
  input  logic [RADIX_W-1:0] cfg_wdata
);

  localparam int NIB = (VALUE_WIDTH + DIGIT_W - 1) / DIGIT_W;
  localparam int PW  = NIB * DIGIT_W;
  localparam int AW  = $clog2(STACK_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_PREFIX, S_DIV, S_POP} state_t;
  typedef enum logic [1:0] {PK_MINUS, PK_NIL, PK_HEX} pfx_t;

  state_t             state;
  pfx_t               pk;
  logic [2:0]         pidx;
  logic [COUNT_W-1:0] total;
  logic [COUNT_W-1:0] cnt;
  logic [RADIX_W-1:0] rad_cur;
  logic               upper_cur;
  logic [RADIX_W-1:0] radix_reg;
  logic               upper_reg;
  logic               pend;
  logic               pend_last;

  div_ctrl_t          div_ctrl;
  div_stat_t          div_stat;
  logic [PW-1:0]      load_value;
  logic [PW-1:0]      quotient;
  logic [DIGIT_W-1:0] remainder;
  logic [DIGIT_W-1:0] rd_data;
  logic [COUNT_W-1:0] total_dec;

  logic [31:0]        mag;
  logic               ptr_zero;
  logic [RADIX_W-1:0] rad_clamp;
  logic               accept;
  logic               quot_zero;
  logic               div_stop;
  logic [7:0]         pfx_char;
  logic [2:0]         pfx_end;
  logic [7:0]         dig_char;

  assign busy      = (state != S_IDLE);
  assign accept    = start && !busy;
  assign mag       = value[31] ? (32'd0 - value[31:0]) : value[31:0];
  assign ptr_zero  = (value[VALUE_WIDTH-1:0] == '0);
  assign quot_zero = (quotient == '0);
  assign div_stop  = quot_zero || (total == COUNT_W'(STACK_DEPTH - 1));
  assign total_dec = total - 1'b1;

  always_comb begin
    if (radix_reg < RADIX_MIN) begin
      rad_clamp = RADIX_MIN;
    end else if (radix_reg > RADIX_HEX) begin
      rad_clamp = RADIX_HEX;
    end else begin
      rad_clamp = radix_reg;
    end
  end

  always_comb begin
    if (operation == OP_SIGNED) begin
      load_value = PW'(mag);
    end else begin
      load_value = PW'(value[VALUE_WIDTH-1:0]);
    end
  end

  assign div_ctrl.load = accept && ((operation == OP_SIGNED) || (operation == OP_RADIX) ||
                                    ((operation == OP_POINTER) && !ptr_zero));
  assign div_ctrl.restart = (state == S_DIV) && div_stat.done && !div_stop;

  always_comb begin
    pfx_char = "-";
    pfx_end  = 3'd0;
    unique case (pk)
      PK_MINUS: begin
        pfx_char = "-";
        pfx_end  = 3'd0;
      end
      PK_NIL: begin
        pfx_end = 3'd4;
        unique case (pidx)
          3'd0:    pfx_char = "(";
          3'd1:    pfx_char = "n";
          3'd2:    pfx_char = "i";
          3'd3:    pfx_char = "l";
          default: pfx_char = ")";
        endcase
      end
      PK_HEX: begin
        pfx_end  = 3'd1;
        pfx_char = (pidx == 3'd0) ? "0" : "x";
      end
      default: begin
        pfx_char = "-";
        pfx_end  = 3'd0;
      end
    endcase
  end

  always_comb begin
    if (rd_data < 4'd10) begin
      dig_char = CH_ZERO + 8'(rd_data);
    end else begin
      dig_char = (upper_cur ? CH_UPPER : CH_LOWER) + 8'(rd_data - 4'd10);
    end
  end

  i2a_divider #(
    .DIV_WIDTH(PW)
  ) u_divider (
    .clk       (clk),
    .rst       (rst),
    .ctrl      (div_ctrl),
    .load_value(load_value),
    .divisor   (rad_cur),
    .stat      (div_stat),
    .quotient  (quotient),
    .remainder (remainder)
  );

  i2a_stack #(
    .DEPTH(STACK_DEPTH)
  ) u_stack (
    .clk  (clk),
    .we   ((state == S_DIV) && div_stat.done),
    .waddr(total[AW-1:0]),
    .wdata(remainder),
    .re   ((state == S_POP) && (total != '0)),
    .raddr(total_dec[AW-1:0]),
    .rdata(rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      strobe    <= 1'b0;
      radix_reg <= RADIX_HEX;
      upper_reg <= 1'b0;
      pend      <= 1'b0;
      cnt       <= '0;
      total     <= '0;
    end else begin
      strobe <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_addr)
          REG_RADIX: radix_reg <= cfg_wdata;
          REG_UPPER: upper_reg <= cfg_wdata[0];
          default:   ;
        endcase
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            cnt   <= '0;
            total <= '0;
            pend  <= 1'b0;
            pidx  <= '0;
            unique case (operation)
              OP_SIGNED: begin
                rad_cur   <= RADIX_DEC;
                upper_cur <= 1'b0;
                pk        <= PK_MINUS;
                state     <= value[31] ? S_PREFIX : S_DIV;
              end
              OP_RADIX: begin
                rad_cur   <= rad_clamp;
                upper_cur <= upper_reg;
                state     <= S_DIV;
              end
              OP_POINTER: begin
                rad_cur   <= RADIX_HEX;
                upper_cur <= 1'b0;
                pk        <= ptr_zero ? PK_NIL : PK_HEX;
                state     <= S_PREFIX;
              end
              default: ;
            endcase
          end
        end
        S_PREFIX: begin
          strobe     <= 1'b1;
          character  <= pfx_char;
          last       <= (pk == PK_NIL) && (pidx == pfx_end);
          char_count <= cnt + 1'b1;
          cnt        <= cnt + 1'b1;
          pidx       <= pidx + 1'b1;
          if (pidx == pfx_end) begin
            state <= (pk == PK_NIL) ? S_IDLE : S_DIV;
          end
        end
        S_DIV: begin
          if (div_stat.done) begin
            total <= total + 1'b1;
            if (div_stop) begin
              state <= S_POP;
            end
          end
        end
        S_POP: begin
          // read issued here; the digit passes the stack's rdata register and then the character register
          if (total != '0) begin
            total     <= total_dec;
            pend      <= 1'b1;
            pend_last <= (total == COUNT_W'(1));
          end else begin
            pend <= 1'b0;
          end
          if (pend) begin
            strobe     <= 1'b1;
            character  <= dig_char;
            last       <= pend_last;
            char_count <= cnt + 1'b1;
            cnt        <= cnt + 1'b1;
            if (pend_last) begin
              state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
